FILE: rtl/ihex_pkg.sv
// Shared types and constants for the Intel HEX record parser.
// Holds the phase encoding, result and error codes, and the hex digit decoder.
// No dependencies.
package ihex_pkg;

  // One-hot parse phases
  typedef enum logic [9:0] {
    PH_COLON = 10'b00_0000_0001,
    PH_COUNT = 10'b00_0000_0010,
    PH_OFFHI = 10'b00_0000_0100,
    PH_OFFLO = 10'b00_0000_1000,
    PH_TYPE  = 10'b00_0001_0000,
    PH_DATA  = 10'b00_0010_0000,
    PH_CHECK = 10'b00_0100_0000,
    PH_EOL   = 10'b00_1000_0000,
    PH_DONE  = 10'b01_0000_0000,
    PH_ERROR = 10'b10_0000_0000
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_EARLY_END = 3'd1;
  localparam logic [2:0] ERR_NO_COLON  = 3'd2;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM  = 3'd4;
  localparam logic [2:0] ERR_BAD_LEN04 = 3'd5;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd6;
  localparam logic [2:0] ERR_BAD_EOL   = 3'd7;

  // Record types
  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_ELA  = 8'h04;

  // Characters
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_LF    = 8'h0a;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // ASCII hex digit, either case
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] diff;
    d.ok    = 1'b0;
    d.value = 4'h0;
    diff    = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      diff    = c - 8'h30;
      d.ok    = 1'b1;
      d.value = diff[3:0];
    end else if (c inside {[8'h61:8'h66]}) begin
      diff    = c - 8'h57;
      d.ok    = 1'b1;
      d.value = diff[3:0];
    end else if (c inside {[8'h41:8'h46]}) begin
      diff    = c - 8'h37;
      d.ok    = 1'b1;
      d.value = diff[3:0];
    end
    return d;
  endfunction

endpackage

FILE: rtl/intel_hex_record_parser_top.sv
// Intel HEX record parser, top level: character decoder, record state and
// result register. Depends on ihex_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  source   | src_valid/src_stall  | character[7:0], end_of_input
//  result   | res_valid/res_stall  | kind[1:0], address[31:0], data_byte[7:0],
//           |                      | error_code[2:0]
//
// One character per cycle while src_stall is low: each transfer updates the parse
// state in the same cycle and loads at most one result into the result register.
// A result appears on the result port the cycle after its character transfer.
// The single result register sets the limit: src_stall is high only while a
// result is held and res_stall is high.
// rst is synchronous and active high; the parser then waits for a colon.
module intel_hex_record_parser_top
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // character stream
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  character,
  input  logic        end_of_input,
  // results
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [31:0] address,
  output logic [7:0]  data_byte,
  output logic [2:0]  error_code
);

  // Parse state
  phase_t      phase, phase_next;
  logic        second_nibble_pending, second_nibble_pending_next;
  logic [3:0]  upper_nibble, upper_nibble_next;
  logic [7:0]  record_length, record_length_next;
  logic [7:0]  bytes_remaining, bytes_remaining_next;
  logic [15:0] record_offset, record_offset_next;
  logic [7:0]  rec_type, rec_type_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] extended_base, extended_base_next;
  logic [7:0]  first_extension_byte, first_extension_byte_next;

  // Result produced by this transfer
  logic        res_load;
  logic [1:0]  kind_next;
  logic [31:0] address_next;
  logic [7:0]  data_byte_next;
  logic [2:0]  error_code_next;

  logic        accept;
  hex_digit_t  digit;
  logic [7:0]  cur_byte;
  logic [7:0]  byte_index;
  logic [7:0]  remaining_dec;
  logic [7:0]  check_sum;

  // A transfer may load a result, so hold off while one is stuck
  assign src_stall = res_valid & res_stall;
  assign accept    = src_valid & ~src_stall;

  assign digit         = hex_decode(character);
  assign cur_byte      = {upper_nibble, digit.value};
  assign byte_index    = record_length - bytes_remaining;
  assign remaining_dec = bytes_remaining - 8'd1;
  assign check_sum     = running_sum + cur_byte;

  always_comb begin
    phase_next                 = phase;
    second_nibble_pending_next = second_nibble_pending;
    upper_nibble_next          = upper_nibble;
    record_length_next         = record_length;
    bytes_remaining_next       = bytes_remaining;
    record_offset_next         = record_offset;
    rec_type_next              = rec_type;
    running_sum_next           = running_sum;
    extended_base_next         = extended_base;
    first_extension_byte_next  = first_extension_byte;
    res_load                   = 1'b0;
    kind_next                  = KIND_DATA;
    address_next               = 32'h0;
    data_byte_next             = 8'h00;
    error_code_next            = ERR_NONE;

    if (accept && phase != PH_DONE && phase != PH_ERROR) begin
      if (end_of_input) begin
        res_load        = 1'b1;
        kind_next       = KIND_ERROR;
        error_code_next = ERR_EARLY_END;
        phase_next      = PH_ERROR;
      end else if (phase == PH_COLON) begin
        if (character != CHAR_COLON) begin
          res_load        = 1'b1;
          kind_next       = KIND_ERROR;
          error_code_next = ERR_NO_COLON;
          phase_next      = PH_ERROR;
        end else begin
          second_nibble_pending_next = 1'b0;
          phase_next                 = PH_COUNT;
        end
      end else if (phase == PH_EOL) begin
        if (character != CHAR_LF) begin
          res_load        = 1'b1;
          kind_next       = KIND_ERROR;
          error_code_next = ERR_BAD_EOL;
          phase_next      = PH_ERROR;
        end else begin
          phase_next = PH_COLON;
        end
      end else if (!digit.ok) begin
        res_load        = 1'b1;
        kind_next       = KIND_ERROR;
        error_code_next = ERR_BAD_HEX;
        phase_next      = PH_ERROR;
      end else if (!second_nibble_pending) begin
        upper_nibble_next          = digit.value;
        second_nibble_pending_next = 1'b1;
      end else begin
        second_nibble_pending_next = 1'b0;
        case (phase)
          PH_COUNT: begin
            record_length_next   = cur_byte;
            bytes_remaining_next = cur_byte;
            running_sum_next     = cur_byte;
            phase_next           = PH_OFFHI;
          end
          PH_OFFHI: begin
            record_offset_next = {cur_byte, 8'h00};
            running_sum_next   = check_sum;
            phase_next         = PH_OFFLO;
          end
          PH_OFFLO: begin
            record_offset_next = {record_offset[15:8], cur_byte};
            running_sum_next   = check_sum;
            phase_next         = PH_TYPE;
          end
          PH_TYPE: begin
            rec_type_next    = cur_byte;
            running_sum_next = check_sum;
            phase_next       = (record_length == 8'h00) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            running_sum_next = check_sum;
            if (rec_type == REC_DATA) begin
              // data bytes go out before the line's checksum is seen
              res_load       = 1'b1;
              kind_next      = KIND_DATA;
              address_next   = {extended_base, 16'h0000} + {16'h0000, record_offset}
                               + {24'h000000, byte_index};
              data_byte_next = cur_byte;
            end else if (rec_type == REC_ELA) begin
              // new base is staged in record_offset until the checksum passes
              if (byte_index == 8'd0) begin
                first_extension_byte_next = cur_byte;
              end else if (byte_index == 8'd1) begin
                record_offset_next = {first_extension_byte, cur_byte};
              end
            end
            bytes_remaining_next = remaining_dec;
            if (remaining_dec == 8'h00) begin
              phase_next = PH_CHECK;
            end
          end
          PH_CHECK: begin
            if (check_sum != 8'h00) begin
              res_load        = 1'b1;
              kind_next       = KIND_ERROR;
              error_code_next = ERR_CHECKSUM;
              phase_next      = PH_ERROR;
            end else if (rec_type == REC_DATA) begin
              phase_next = PH_EOL;
            end else if (rec_type == REC_EOF) begin
              res_load   = 1'b1;
              kind_next  = KIND_FINISH;
              phase_next = PH_DONE;
            end else if (rec_type == REC_ELA) begin
              if (record_length != 8'd2) begin
                res_load        = 1'b1;
                kind_next       = KIND_ERROR;
                error_code_next = ERR_BAD_LEN04;
                phase_next      = PH_ERROR;
              end else begin
                extended_base_next = record_offset;
                phase_next         = PH_EOL;
              end
            end else begin
              res_load        = 1'b1;
              kind_next       = KIND_ERROR;
              error_code_next = ERR_BAD_TYPE;
              phase_next      = PH_ERROR;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase                 <= PH_COLON;
      second_nibble_pending <= 1'b0;
      upper_nibble          <= 4'h0;
      record_length         <= 8'h00;
      bytes_remaining       <= 8'h00;
      record_offset         <= 16'h0000;
      rec_type              <= 8'h00;
      running_sum           <= 8'h00;
      extended_base         <= 16'h0000;
      first_extension_byte  <= 8'h00;
    end else begin
      phase                 <= phase_next;
      second_nibble_pending <= second_nibble_pending_next;
      upper_nibble          <= upper_nibble_next;
      record_length         <= record_length_next;
      bytes_remaining       <= bytes_remaining_next;
      record_offset         <= record_offset_next;
      rec_type              <= rec_type_next;
      running_sum           <= running_sum_next;
      extended_base         <= extended_base_next;
      first_extension_byte  <= first_extension_byte_next;
    end
  end

  // Result register: filled on a producing transfer, emptied when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      kind       <= kind_next;
      address    <= address_next;
      data_byte  <= data_byte_next;
      error_code <= error_code_next;
    end
  end

`ifndef SYNTHESIS
  // Nothing is produced once parsing has finished or failed
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE || phase == PH_ERROR) |-> !res_load)
    else $error("result produced after finish or error");

  // Input is held back only by a stalled, occupied result register
  assert property (@(posedge clk) disable iff (rst)
    src_stall |-> res_valid)
    else $error("source stalled with empty result register");

  // An error result leaves the parser in the error phase
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == KIND_ERROR) |-> phase == PH_ERROR)
    else $error("error result without error phase");

  // A finish result leaves the parser in the done phase
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == KIND_FINISH) |-> phase == PH_DONE)
    else $error("finish result without done phase");
`endif

endmodule

FILE: tb/sv/tb.sv
// Testbench for intel_hex_record_parser_top: directed and random Intel HEX character
// streams, checked against a cycle-free predictor of the record parser.
// Depends on ihex_pkg and the parser RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ihex_pkg::*;

  localparam int         RANDOM_ITEMS = 1250;
  localparam int         HOLD_CYCLES  = 150;
  localparam logic [7:0] CHAR_CR      = 8'h0d;

  // One result transfer, as seen on the result port
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
  } parse_result_t;

  // Directed row: a text fragment; when pinned, the result of its last
  // character is typed in here instead of taken from the predictor.
  typedef struct {
    string         text;
    bit            pinned;
    parse_result_t want;
  } dir_row_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        src_valid    = 1'b0;
  logic        src_stall;
  logic [7:0]  character    = 8'h00;
  logic        end_of_input = 1'b0;
  logic        res_valid;
  logic        res_stall    = 1'b0;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [7:0]  data_byte;
  logic [2:0]  error_code;

  intel_hex_record_parser_top dut (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .character    (character),
    .end_of_input (end_of_input),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .address      (address),
    .data_byte    (data_byte),
    .error_code   (error_code)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: mirror of the parser's record registers
  // ---------------------------------------------------------------------------
  phase_t      p_phase;
  logic        p_hi_pending;
  logic [3:0]  p_hi;
  logic [7:0]  p_len;
  logic [7:0]  p_left;
  logic [15:0] p_off;      // also holds the pending base during a type 04 record
  logic [7:0]  p_type;
  logic [7:0]  p_sum;
  logic [15:0] p_base;
  logic [7:0]  p_ext_first;

  parse_result_t pending_results[$];   // expected results, oldest first
  int            mismatches    = 0;
  int            chars_sent    = 0;
  int            send_idle_pct = 0;
  int            stall_pct     = 0;
  bit            hold_req      = 1'b0;
  bit            pin_on        = 1'b0;
  parse_result_t pin_want;

  logic [8:0] text_q[$];      // {end_of_input, character} waiting to go out
  logic [7:0] rec_bytes[$];   // data field of the record being built
  dir_row_t   rows[$];        // directed stimulus table

  function automatic void parser_reset();
    p_phase      = PH_COLON;
    p_hi_pending = 1'b0;
    p_hi         = 4'h0;
    p_len        = 8'h00;
    p_left       = 8'h00;
    p_off        = 16'h0000;
    p_type       = 8'h00;
    p_sum        = 8'h00;
    p_base       = 16'h0000;
    p_ext_first  = 8'h00;
  endfunction

  // -1 when c is no hex digit
  function automatic int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
    return -1;
  endfunction

  // Fault: parser goes silent for good
  function automatic parse_result_t parse_fault(logic [2:0] code);
    p_phase = PH_ERROR;
    return '{KIND_ERROR, 32'h0, 8'h00, code};
  endfunction

  // Advance the predictor by one character transfer; returns 1 with r set
  // when the transfer produces a result.
  function automatic bit hex_parse_step(input logic [7:0] c, input logic eoi,
                                        output parse_result_t r);
    int          v;
    logic [7:0]  b;
    logic [7:0]  idx;
    logic [7:0]  total;
    logic [31:0] addr;
    bit          got;
    got = 1'b0;
    r   = '{KIND_DATA, 32'h0, 8'h00, ERR_NONE};
    if (p_phase == PH_DONE || p_phase == PH_ERROR) return 1'b0;
    if (eoi) begin
      r = parse_fault(ERR_EARLY_END);
      return 1'b1;
    end
    if (p_phase == PH_COLON) begin
      if (c != CHAR_COLON) begin
        r = parse_fault(ERR_NO_COLON);
        return 1'b1;
      end
      p_hi_pending = 1'b0;
      p_phase      = PH_COUNT;
      return 1'b0;
    end
    if (p_phase == PH_EOL) begin
      if (c != CHAR_LF) begin
        r = parse_fault(ERR_BAD_EOL);
        return 1'b1;
      end
      p_phase = PH_COLON;
      return 1'b0;
    end
    v = nibble_of(c);
    if (v < 0) begin
      r = parse_fault(ERR_BAD_HEX);
      return 1'b1;
    end
    if (!p_hi_pending) begin
      p_hi         = v[3:0];
      p_hi_pending = 1'b1;
      return 1'b0;
    end
    p_hi_pending = 1'b0;
    b = {p_hi, v[3:0]};
    case (p_phase)
      PH_COUNT: begin
        p_len   = b;
        p_left  = b;
        p_sum   = b;
        p_phase = PH_OFFHI;
      end
      PH_OFFHI: begin
        p_off   = {b, 8'h00};
        p_sum   = p_sum + b;
        p_phase = PH_OFFLO;
      end
      PH_OFFLO: begin
        p_off[7:0] = b;
        p_sum      = p_sum + b;
        p_phase    = PH_TYPE;
      end
      PH_TYPE: begin
        p_type  = b;
        p_sum   = p_sum + b;
        p_phase = (p_len == 8'h00) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        idx   = p_len - p_left;
        p_sum = p_sum + b;
        if (p_type == REC_DATA) begin
          addr = {p_base, 16'h0000} + {16'h0000, p_off} + {24'h000000, idx};
          r    = '{KIND_DATA, addr, b, ERR_NONE};
          got  = 1'b1;
        end else if (p_type == REC_ELA) begin
          if (idx == 8'd0) p_ext_first = b;
          else if (idx == 8'd1) p_off = {p_ext_first, b};
        end
        p_left = p_left - 8'd1;
        if (p_left == 8'h00) p_phase = PH_CHECK;
      end
      PH_CHECK: begin
        total = p_sum + b;
        got   = 1'b1;
        // checksum wins over length and type faults
        if (total != 8'h00) r = parse_fault(ERR_CHECKSUM);
        else if (p_type == REC_DATA) begin
          p_phase = PH_EOL;
          got     = 1'b0;
        end else if (p_type == REC_EOF) begin
          p_phase = PH_DONE;
          r       = '{KIND_FINISH, 32'h0, 8'h00, ERR_NONE};
        end else if (p_type == REC_ELA) begin
          if (p_len != 8'd2) r = parse_fault(ERR_BAD_LEN04);
          else begin
            p_base  = p_off;   // new base only once the record proved good
            p_phase = PH_EOL;
            got     = 1'b0;
          end
        end else r = parse_fault(ERR_BAD_TYPE);
      end
      default: ;
    endcase
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // Record text builders
  // ---------------------------------------------------------------------------
  // letters in either case, chosen per digit
  function automatic logic [7:0] hex_digit(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic void add_char(logic eoi, logic [7:0] c);
    text_q.insert(text_q.size(), {eoi, c});
  endfunction

  function automatic void add_row(string text, bit pinned, parse_result_t want);
    dir_row_t row;
    row.text   = text;
    row.pinned = pinned;
    row.want   = want;
    rows.insert(rows.size(), row);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    add_char(1'b0, hex_digit(b[7:4]));
    add_char(1'b0, hex_digit(b[3:0]));
  endfunction

  function automatic void fill_bytes(int n);
    rec_bytes.delete();
    repeat (n) rec_bytes.insert(rec_bytes.size(), 8'($urandom));
  endfunction

  // ':' count offset type data checksum, no line feed; sum_skew != 0 spoils
  // the checksum
  function automatic void add_record(logic [7:0] typ, logic [15:0] off,
                                     logic [7:0] sum_skew);
    logic [7:0] sum;
    sum = 8'(rec_bytes.size()) + off[15:8] + off[7:0] + typ;
    add_char(1'b0, CHAR_COLON);
    add_byte(8'(rec_bytes.size()));
    add_byte(off[15:8]);
    add_byte(off[7:0]);
    add_byte(typ);
    foreach (rec_bytes[i]) begin
      add_byte(rec_bytes[i]);
      sum = sum + rec_bytes[i];
    end
    add_byte(8'h00 - sum + sum_skew);
  endfunction

  function automatic logic [7:0] random_char_except(logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom); while (c == avoid);
    return c;
  endfunction

  function automatic void cut_text(int keep);
    while (text_q.size() > keep) void'(text_q.pop_back());
  endfunction

  // Type 00 record: offsets often near the top so address sums carry
  function automatic void add_data_record(int n);
    logic [15:0] off;
    off = $urandom_range(2) == 0 ? (16'hfff0 | 16'($urandom_range(15))) : 16'($urandom);
    fill_bytes(n);
    add_record(REC_DATA, off, 8'h00);
  endfunction

  // Type 04 record: the offset field is don't-care; base often all ones
  function automatic void add_base_record();
    fill_bytes(2);
    if ($urandom_range(3) == 0) begin
      rec_bytes[0] = 8'hff;
      rec_bytes[1] = 8'hff;
    end
    add_record(REC_ELA, 16'($urandom), 8'h00);
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: called at a falling edge, returns at a falling edge after
  // the transfer. Payload holds while stalled.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid    <= 1'b1;
    character    <= c;
    end_of_input <= eoi;
    do @(posedge clk); while (src_stall);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    logic [8:0] item;
    while (text_q.size() != 0) begin
      item = text_q.pop_front();
      send_char(item[7:0], item[8]);
    end
  endtask

  // Source goes quiet until every expected result has been taken
  task automatic wait_for_drain();
    src_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, plus one long hold-off on request so the
  // result register fills and back-pressure reaches the source
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on each source transfer, compare on each result
  // transfer. Sampled at the rising edge, before the DUT's registers move.
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    parse_result_t predicted;
    parse_result_t oldest;
    bit            produced;
    if (!rst) begin
      if (src_valid && !src_stall) begin
        produced = hex_parse_step(character, end_of_input, predicted);
        if (pin_on) begin
          predicted = pin_want;
          produced  = 1'b1;
          pin_on    = 1'b0;
        end
        if (produced) pending_results.insert(pending_results.size(), predicted);
      end
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with none expected: kind %0d addr 0x%0h data 0x%0h err %0d",
                 kind, address, data_byte, error_code);
          mismatches++;
        end else begin
          oldest = pending_results.pop_front();
          compare_field("kind", 32'(oldest.kind), 32'(kind));
          compare_field("address", oldest.address, address);
          compare_field("data_byte", 32'(oldest.data_byte), 32'(data_byte));
          compare_field("error_code", 32'(oldest.error_code), 32'(error_code));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int         idle_phase;
    int         ending;
    int         cut;
    bit         held;
    bit         long_done;
    bit         drained;
    logic [7:0] c;
    logic [7:0] typ;
    held      = 1'b0;
    long_done = 1'b0;
    drained   = 1'b0;
    parser_reset();

    // Directed: base FFFF (lower-case digits), then one byte FF at offset
    // FFFF, which must land on the very top address.
    add_row(":02000004", 1'b0, '0);
    add_row("ffff", 1'b0, '0);
    add_row("fc\n", 1'b0, '0);
    add_row(":01FFFF00F", 1'b0, '0);
    add_row("F", 1'b1, '{KIND_DATA, 32'hffff_ffff, 8'hff, ERR_NONE});
    add_row("02\n", 1'b0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[r]) begin
      for (int i = 0; i < rows[r].text.len(); i++) begin
        if (rows[r].pinned && i == rows[r].text.len() - 1) begin
          pin_want = rows[r].want;
          pin_on   = 1'b1;
        end
        send_char(rows[r].text[i], 1'b0);
      end
    end

    // Random well-formed records through four idling phases
    chars_sent = 0;
    while (chars_sent < RANDOM_ITEMS) begin
      idle_phase = chars_sent * 4 / RANDOM_ITEMS;
      case (idle_phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 58;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 58;
        end
        default: begin
          send_idle_pct = 24;
          stall_pct     = 24;
        end
      endcase
      if (!held) begin
        // long result hold-off while the source keeps pushing data bytes
        held     = 1'b1;
        hold_req = 1'b1;
        add_data_record(48);
      end else if (idle_phase == 1 && !long_done) begin
        long_done = 1'b1;
        add_data_record(255);
      end else if (idle_phase == 2 && !drained) begin
        drained = 1'b1;
        wait_for_drain();
      end else if ($urandom_range(99) < 15) add_base_record();
      else add_data_record($urandom_range(16));
      if (text_q.size() != 0) add_char(1'b0, CHAR_LF);
      send_text();
    end

    // One terminating event; the parser is silent afterwards
    ending = $urandom_range(7);
    case (ending)
      0: begin  // end-of-file record, possibly with data
        fill_bytes($urandom_range(3));
        add_record(REC_EOF, 16'($urandom), 8'h00);
        add_char(1'b0, CHAR_LF);
      end
      1: begin  // end of input anywhere, line start included
        add_data_record($urandom_range(4));
        add_char(1'b0, CHAR_LF);
        cut = $urandom_range(text_q.size());
        cut_text(cut);
        add_char(1'b1, 8'($urandom));
      end
      2: add_char(1'b0, random_char_except(CHAR_COLON));
      3: begin  // non-hex character where a digit belongs
        add_data_record($urandom_range(4));
        cut = $urandom_range(1, text_q.size() - 1);
        cut_text(cut);
        do c = 8'($urandom); while (nibble_of(c) >= 0);
        add_char(1'b0, c);
      end
      4: begin  // bad checksum, any record type
        case ($urandom_range(3))
          0: typ = REC_DATA;
          1: typ = REC_EOF;
          2: typ = REC_ELA;
          default: typ = 8'($urandom);
        endcase
        fill_bytes($urandom_range(5));
        add_record(typ, 16'($urandom), 8'($urandom_range(1, 255)));
        add_char(1'b0, CHAR_LF);
      end
      5: begin  // extended address record of the wrong length
        cut = $urandom_range(3);
        fill_bytes(cut < 2 ? cut : cut + 1);
        add_record(REC_ELA, 16'($urandom), 8'h00);
        add_char(1'b0, CHAR_LF);
      end
      6: begin  // unknown record type
        do typ = 8'($urandom); while (typ == REC_DATA || typ == REC_EOF || typ == REC_ELA);
        fill_bytes($urandom_range(4));
        add_record(typ, 16'($urandom), 8'h00);
        add_char(1'b0, CHAR_LF);
      end
      default: begin  // good record, then anything but a line feed
        if ($urandom_range(1)) add_base_record();
        else add_data_record($urandom_range(4));
        add_char(1'b0, $urandom_range(1) ? CHAR_CR : random_char_except(CHAR_LF));
      end
    endcase
    send_text();

    // Trailing noise, all of it ignored by the parser
    repeat (40) send_char(8'($urandom), $urandom_range(3) == 0);

    wait_for_drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
